/* rtl/jlte_pkg.sv */
package jlte_pkg;

	typedef logic signed [63:0] q64_t;

	typedef enum logic [1:0] {
		OP_POS,
		OP_VEL,
		OP_STOP
	} op_t;

	typedef enum logic {
		CFG_MAX_ACCEL,
		CFG_JERK_DURATION
	} cfg_idx_t;

	localparam logic [30:0] MAX_ACCEL_RST = 31'd262144;
	localparam logic [30:0] JERK_DUR_RST = 31'd13107;

	localparam q64_t Q64_MAX = {1'b0, {63{1'b1}}};
	localparam q64_t Q64_MIN = {1'b1, {63{1'b0}}};

	typedef struct packed {
		logic [1:0] op;
		logic [30:0] query_time;
		logic signed [31:0] cmd_accel_x;
		logic signed [31:0] cmd_accel_y;
		logic signed [31:0] cmd_accel_z;
		logic signed [31:0] init_accel_x;
		logic signed [31:0] init_accel_y;
		logic signed [31:0] init_accel_z;
		logic signed [31:0] init_vel_x;
		logic signed [31:0] init_vel_y;
		logic signed [31:0] init_vel_z;
	} item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic stopped_in_jerk;
		logic zero_speed;
	} res_t;

	// Saturating add; the 65-bit sum is exact.
	function automatic q64_t sadd(input q64_t a, input q64_t b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? Q64_MIN : Q64_MAX;
		end
		return s[63:0];
	endfunction

	// Saturating subtract, same as the exact difference clamped to 64 bits.
	function automatic q64_t ssub(input q64_t a, input q64_t b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? Q64_MIN : Q64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic q64_t sneg(input q64_t a);
		return (a == Q64_MIN) ? Q64_MAX : -a;
	endfunction

	function automatic logic [63:0] mag(input q64_t a);
		return a[63] ? 64'(-a) : 64'(a);
	endfunction

	// Applies a sign to an unsigned magnitude and clamps to 64 bits.
	function automatic q64_t ssat(input logic neg, input logic [63:0] m);
		if (neg) begin
			return m[63] ? Q64_MIN : -q64_t'(m);
		end
		return m[63] ? Q64_MAX : q64_t'(m);
	endfunction

	function automatic logic signed [31:0] sat32(input q64_t a);
		if (a > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end
		if (a < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return a[31:0];
	endfunction

endpackage

/* rtl/jlte_dly.sv */
module jlte_dly #(
	parameter int W = 64,
	parameter int N = 1
) (
	input logic clk,
	input logic en,
	input logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] r_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= d;
			for (int k = 1; k < N; k++) begin
				r_s[k] <= r_s[k-1];
			end
		end
	end

	assign q = r_s[N-1];

endmodule

/* rtl/jlte_mul.sv */
module jlte_mul import jlte_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic en,
	input q64_t a,
	input q64_t b,
	output q64_t p
);

	logic [63:0] ma, mb;
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic neg_s1;
	logic [127:0] prod, sh;
	logic [63:0] m;
	q64_t p_s2;

	assign ma = mag(a);
	assign mb = mag(b);

	// Four 32x32 partial products, summed in the second stage.
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 64'(ma[31:0]) * 64'(mb[31:0]);
			lh_s1 <= 64'(ma[31:0]) * 64'(mb[63:32]);
			hl_s1 <= 64'(ma[63:32]) * 64'(mb[31:0]);
			hh_s1 <= 64'(ma[63:32]) * 64'(mb[63:32]);
			neg_s1 <= a[63] ^ b[63];
		end
	end

	always_comb begin
		prod = {64'd0, ll_s1} + {32'd0, lh_s1, 32'd0} + {32'd0, hl_s1, 32'd0}
			+ {hh_s1, 64'd0};
		sh = prod >> FRAC_BITS;
		m = (|sh[127:64]) ? {64{1'b1}} : sh[63:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= ssat(neg_s1, m);
		end
	end

	assign p = p_s2;

endmodule

/* rtl/jlte_div.sv */
module jlte_div import jlte_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic en,
	input q64_t a,
	input q64_t b,
	output q64_t q
);

	// Leading numerator bits above this count are zero and give no quotient bits.
	localparam int NSTEP = 64 + FRAC_BITS;

	logic [NSTEP-1:0] num_s [NSTEP+1];
	logic [63:0] rem_s [NSTEP+1];
	logic [63:0] quo_s [NSTEP+1];
	logic [63:0] den_s [NSTEP+1];
	logic hi_s [NSTEP+1];
	logic neg_s [NSTEP+1];
	logic dz_s [NSTEP+1];
	logic nz_s [NSTEP+1];
	q64_t q_s;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= {mag(a), {FRAC_BITS{1'b0}}};
			rem_s[0] <= '0;
			quo_s[0] <= '0;
			den_s[0] <= mag(b);
			hi_s[0] <= 1'b0;
			neg_s[0] <= a[63] ^ b[63];
			dz_s[0] <= (b == '0);
			nz_s[0] <= (a != '0);
		end
	end

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		logic [64:0] r, rd;
		logic ge;

		assign r = {rem_s[k], num_s[k][NSTEP-1]};
		assign ge = (r >= {1'b0, den_s[k]});
		assign rd = r - {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1] <= num_s[k] << 1;
				rem_s[k+1] <= ge ? rd[63:0] : r[63:0];
				quo_s[k+1] <= {quo_s[k][62:0], ge};
				hi_s[k+1] <= hi_s[k] | quo_s[k][63];
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				dz_s[k+1] <= dz_s[k];
				nz_s[k+1] <= nz_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dz_s[NSTEP]) begin
				q_s <= nz_s[NSTEP] ? ssat(neg_s[NSTEP], {64{1'b1}}) : '0;
			end else begin
				q_s <= ssat(neg_s[NSTEP], hi_s[NSTEP] ? {64{1'b1}} : quo_s[NSTEP]);
			end
		end
	end

	assign q = q_s;

endmodule

/* rtl/jlte_norm.sv */
module jlte_norm import jlte_pkg::*; (
	input logic clk,
	input logic en,
	input q64_t x,
	input q64_t y,
	input q64_t z,
	output q64_t n
);

	logic [63:0] m [3];
	logic [63:0] ll_s1 [3], lh_s1 [3], hh_s1 [3];
	logic [127:0] sq_s2 [3];
	logic [127:0] rad_s [65];
	logic [66:0] rm_s [65];
	logic [63:0] rt_s [65];
	q64_t n_s;

	assign m[0] = mag(x);
	assign m[1] = mag(y);
	assign m[2] = mag(z);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ll_s1[i] <= 64'(m[i][31:0]) * 64'(m[i][31:0]);
				lh_s1[i] <= 64'(m[i][31:0]) * 64'(m[i][63:32]);
				hh_s1[i] <= 64'(m[i][63:32]) * 64'(m[i][63:32]);
				sq_s2[i] <= {64'd0, ll_s1[i]} + {31'd0, lh_s1[i], 33'd0}
					+ {hh_s1[i], 64'd0};
			end
			// Each square is at most 2**126, so three of them fit in 128 bits.
			rad_s[0] <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			rm_s[0] <= '0;
			rt_s[0] <= '0;
		end
	end

	// Restoring square root, one result bit per stage.
	for (genvar k = 0; k < 64; k++) begin : g_root
		logic [66:0] rmx, trial;
		logic ge;

		assign rmx = {rm_s[k][64:0], rad_s[k][127:126]};
		assign trial = {1'b0, rt_s[k], 2'b01};
		assign ge = (rmx >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1] <= rad_s[k] << 2;
				rm_s[k+1] <= ge ? rmx - trial : rmx;
				rt_s[k+1] <= {rt_s[k][62:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s <= rt_s[64][63] ? Q64_MAX : q64_t'(rt_s[64]);
		end
	end

	assign n = n_s;

endmodule

/* rtl/jlte_axis.sv */
module jlte_axis import jlte_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic en,
	input q64_t jt,
	input q64_t t,
	input q64_t a,
	input q64_t a0,
	input q64_t v0,
	output q64_t p,
	output q64_t v
);

	localparam int D = 66 + FRAC_BITS;
	localparam int J = 2 + D;
	localparam q64_t QH = q64_t'(64'd1 << (FRAC_BITS - 1));
	localparam q64_t QS = q64_t'(((64'd1666 << FRAC_BITS) + 64'd5000) / 64'd10000);

	q64_t d, tl;
	logic tlt;
	q64_t m_dt, jtt, h1, h2, a0t, a0t_j4, v0_5, v0_j5, vi1_s, vi_s;
	q64_t s1, s2, s3, ha0, ha0t, ha0tt, ha0tt_j6, t_2, t_4, t_j2, t_j4;
	q64_t pi1_s, pi_s, v0t, v0t_j7;
	q64_t hd, hdj, a0j, a0j_4, e1_s, ve_s, sd1, sd2, sd3, ha0j, ha0jj;
	q64_t f1_s, pe_s, v0j, v0j_7, atl, atl_6, vp_s, hat, hatl, hatll, hatll_8;
	q64_t tl_2, tl_4, tl_6, vetl, vetl_9, g1_s, pp_s;
	q64_t vi_j8, vp_j8, pp_j8, p_s, v_s;
	logic tlt_j8;

	assign d = a - a0;
	assign tlt = (t < jt);
	assign tl = t - jt;

	// Delayed copies of the time and initial velocity for the products and sums below.
	jlte_dly #(.W(64), .N(2)) u_t2 (.clk, .en, .d(t), .q(t_2));
	jlte_dly #(.W(64), .N(2)) u_t4 (.clk, .en, .d(t_2), .q(t_4));
	jlte_dly #(.W(64), .N(J-2)) u_tj2 (.clk, .en, .d(t_4), .q(t_j2));
	jlte_dly #(.W(64), .N(2)) u_tj4 (.clk, .en, .d(t_j2), .q(t_j4));
	jlte_dly #(.W(64), .N(2)) u_tl2 (.clk, .en, .d(tl), .q(tl_2));
	jlte_dly #(.W(64), .N(2)) u_tl4 (.clk, .en, .d(tl_2), .q(tl_4));
	jlte_dly #(.W(64), .N(2)) u_tl6 (.clk, .en, .d(tl_4), .q(tl_6));
	jlte_dly #(.W(64), .N(5)) u_v05 (.clk, .en, .d(v0), .q(v0_5));
	jlte_dly #(.W(64), .N(J)) u_v0j5 (.clk, .en, .d(v0_5), .q(v0_j5));

	// Inside the jerk phase.
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_m_dt (.clk, .en, .a(d), .b(t), .p(m_dt));
	jlte_div #(.FRAC_BITS(FRAC_BITS)) u_jtt (.clk, .en, .a(m_dt), .b(jt), .q(jtt));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_h1 (.clk, .en, .a(QH), .b(jtt), .p(h1));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_h2 (.clk, .en, .a(h1), .b(t_j2), .p(h2));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_a0t (.clk, .en, .a(a0), .b(t), .p(a0t));
	jlte_dly #(.W(64), .N(J+2)) u_a0tj (.clk, .en, .d(a0t), .q(a0t_j4));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_s1 (.clk, .en, .a(QS), .b(jtt), .p(s1));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_s2 (.clk, .en, .a(s1), .b(t_j2), .p(s2));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_s3 (.clk, .en, .a(s2), .b(t_j4), .p(s3));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_ha0 (.clk, .en, .a(QH), .b(a0), .p(ha0));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_ha0t (.clk, .en, .a(ha0), .b(t_2), .p(ha0t));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_ha0tt (.clk, .en, .a(ha0t), .b(t_4), .p(ha0tt));
	jlte_dly #(.W(64), .N(J)) u_ha0ttj (.clk, .en, .d(ha0tt), .q(ha0tt_j6));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_v0t (.clk, .en, .a(v0), .b(t), .p(v0t));
	jlte_dly #(.W(64), .N(J+5)) u_v0tj (.clk, .en, .d(v0t), .q(v0t_j7));

	// After the jerk phase.
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_hd (.clk, .en, .a(QH), .b(d), .p(hd));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_hdj (.clk, .en, .a(hd), .b(jt), .p(hdj));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_a0j (.clk, .en, .a(a0), .b(jt), .p(a0j));
	jlte_dly #(.W(64), .N(2)) u_a0j4 (.clk, .en, .d(a0j), .q(a0j_4));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_sd1 (.clk, .en, .a(QS), .b(d), .p(sd1));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_sd2 (.clk, .en, .a(sd1), .b(jt), .p(sd2));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_sd3 (.clk, .en, .a(sd2), .b(jt), .p(sd3));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_ha0j (.clk, .en, .a(ha0), .b(jt), .p(ha0j));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_ha0jj (.clk, .en, .a(ha0j), .b(jt), .p(ha0jj));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_v0j (.clk, .en, .a(v0), .b(jt), .p(v0j));
	jlte_dly #(.W(64), .N(5)) u_v0j7 (.clk, .en, .d(v0j), .q(v0j_7));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_atl (.clk, .en, .a(a), .b(tl), .p(atl));
	jlte_dly #(.W(64), .N(4)) u_atl6 (.clk, .en, .d(atl), .q(atl_6));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_hat (.clk, .en, .a(QH), .b(a), .p(hat));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_hatl (.clk, .en, .a(hat), .b(tl_2), .p(hatl));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_hatll (.clk, .en, .a(hatl), .b(tl_4), .p(hatll));
	jlte_dly #(.W(64), .N(2)) u_hatll8 (.clk, .en, .d(hatll), .q(hatll_8));
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_vetl (.clk, .en, .a(ve_s), .b(tl_6), .p(vetl));
	jlte_dly #(.W(64), .N(1)) u_vetl9 (.clk, .en, .d(vetl), .q(vetl_9));

	// The adds keep the order of the saturating sums, one per stage.
	always_ff @(posedge clk) begin
		if (en) begin
			vi1_s <= sadd(h2, a0t_j4);
			vi_s <= sadd(vi1_s, v0_j5);
			pi1_s <= sadd(s3, ha0tt_j6);
			pi_s <= sadd(pi1_s, v0t_j7);
			e1_s <= sadd(hdj, a0j_4);
			ve_s <= sadd(e1_s, v0_5);
			f1_s <= sadd(sd3, ha0jj);
			pe_s <= sadd(f1_s, v0j_7);
			vp_s <= sadd(ve_s, atl_6);
			g1_s <= sadd(pe_s, hatll_8);
			pp_s <= sadd(g1_s, vetl_9);
		end
	end

	jlte_dly #(.W(64), .N(2)) u_vij8 (.clk, .en, .d(vi_s), .q(vi_j8));
	jlte_dly #(.W(64), .N(J+1)) u_vpj8 (.clk, .en, .d(vp_s), .q(vp_j8));
	jlte_dly #(.W(64), .N(J-2)) u_ppj8 (.clk, .en, .d(pp_s), .q(pp_j8));
	jlte_dly #(.W(1), .N(J+8)) u_tltj8 (.clk, .en, .d(tlt), .q(tlt_j8));

	always_ff @(posedge clk) begin
		if (en) begin
			p_s <= tlt_j8 ? pi_s : pp_j8;
			v_s <= tlt_j8 ? vi_j8 : vp_j8;
		end
	end

	assign p = p_s;
	assign v = v_s;

endmodule

/* rtl/jerk_limited_trajectory_eval_core.sv */
// Channel | Direction | Handshake         | Beat
// item    | in        | item_valid/stall  | item_t: op, time, commanded/initial accel, velocity
// res     | out       | res_valid/stall   | res_t: x, y, z, stop flags
// cfg     | in        | cfg_valid/ready   | cfg_index, cfg_data (always ready)
//
// One beat is accepted per cycle while the result output is not stalled. Three dividers
// and two square roots lie in series on the stop-position path.
// Reset clears only the valid bits and loads the configuration registers with their defaults.
// A stalled result freezes the pipeline but for the free-running braking term, and item_stall rises with it.
module jerk_limited_trajectory_eval_core import jlte_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input item_t item,
	output logic res_valid,
	input logic res_stall,
	output res_t res,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [31:0] cfg_data
);

	localparam int D = 66 + FRAC_BITS;
	localparam int S = 68;
	localparam int A = 11 + D;
	localparam int U = A + S + D;
	localparam int E = U + 14 + S + D;
	localparam q64_t QH = q64_t'(64'd1 << (FRAC_BITS - 1));
	localparam q64_t QS = q64_t'(((64'd1666 << FRAC_BITS) + 64'd5000) / 64'd10000);
	localparam q64_t QB = q64_t'(((64'd65 << FRAC_BITS) + 64'd50) / 64'd100);

	logic [30:0] amax_q, jt_q;
	logic [E+1:0] vld_q;
	logic adv;
	q64_t jt64, amax64, brk, brk2_q;

	logic [1:0] op_s0;
	q64_t t_s0;
	q64_t a_s0 [3], a0_s0 [3], v0_s0 [3];

	q64_t p_a [3], v_a [3], v_as [3], unit [3], vjs_s [3], m_d [3], pjs_s [3];
	q64_t p_e [3], v_e [3], pjs_e [3], r_s [3];
	q64_t speed, m2_d, dot1_s, dot_s;
	q64_t s_brk, ss, brake_len;
	logic [1:0] op_e;
	logic zero_e, inj_e;
	q64_t rsel [3];
	res_t res_d, res_q;

	assign cfg_ready = 1'b1;
	assign jt64 = {33'd0, jt_q};
	assign amax64 = {33'd0, amax_q};
	assign adv = !(res_valid && res_stall);
	assign item_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amax_q <= MAX_ACCEL_RST;
			jt_q <= JERK_DUR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_ACCEL: amax_q <= cfg_data[30:0];
				CFG_JERK_DURATION: jt_q <= cfg_data[30:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[E:0], item_valid};
		end
	end

	assign res_valid = vld_q[E+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s0 <= item.op;
			t_s0 <= {33'd0, item.query_time};
			a_s0[0] <= {{32{item.cmd_accel_x[31]}}, item.cmd_accel_x};
			a_s0[1] <= {{32{item.cmd_accel_y[31]}}, item.cmd_accel_y};
			a_s0[2] <= {{32{item.cmd_accel_z[31]}}, item.cmd_accel_z};
			a0_s0[0] <= {{32{item.init_accel_x[31]}}, item.init_accel_x};
			a0_s0[1] <= {{32{item.init_accel_y[31]}}, item.init_accel_y};
			a0_s0[2] <= {{32{item.init_accel_z[31]}}, item.init_accel_z};
			v0_s0[0] <= {{32{item.init_vel_x[31]}}, item.init_vel_x};
			v0_s0[1] <= {{32{item.init_vel_y[31]}}, item.init_vel_y};
			v0_s0[2] <= {{32{item.init_vel_z[31]}}, item.init_vel_z};
		end
	end

	// Braking term depends on configuration only, so it runs freely.
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_brk (
		.clk, .en(1'b1), .a(amax64), .b(QB), .p(brk)
	);

	always_ff @(posedge clk) begin
		brk2_q <= sadd(brk, brk);
	end

	jlte_norm u_spd (.clk, .en(adv), .x(v_a[0]), .y(v_a[1]), .z(v_a[2]), .n(speed));

	for (genvar i = 0; i < 3; i++) begin : g_ax
		q64_t a_a, a_u2, ms, sd_s, k1, k2, k3, ha, haj, hajj, hajj_u9, vj, vj_u10;
		q64_t q1_s, q2_s, p_u11, l1, l2, aj, aj_u7, w1_s, v_u8, v_u9;
		q64_t unit_d, mr;
		q64_t pjs_d;

		jlte_axis #(.FRAC_BITS(FRAC_BITS)) u_axis (
			.clk, .en(adv), .jt(jt64), .t(t_s0), .a(a_s0[i]), .a0(a0_s0[i]),
			.v0(v0_s0[i]), .p(p_a[i]), .v(v_a[i])
		);

		jlte_dly #(.W(64), .N(A)) u_aa (.clk, .en(adv), .d(a_s0[i]), .q(a_a));
		jlte_dly #(.W(64), .N(S)) u_vas (.clk, .en(adv), .d(v_a[i]), .q(v_as[i]));

		jlte_div #(.FRAC_BITS(FRAC_BITS)) u_unit (
			.clk, .en(adv), .a(sneg(v_as[i])), .b(speed), .q(unit[i])
		);

		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_ms (
			.clk, .en(adv), .a(amax64), .b(unit[i]), .p(ms)
		);
		jlte_dly #(.W(64), .N(U+2-A)) u_au2 (.clk, .en(adv), .d(a_a), .q(a_u2));

		// Braking jerk toward the opposite of the velocity.
		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_k1 (.clk, .en(adv), .a(QS), .b(sd_s), .p(k1));
		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_k2 (.clk, .en(adv), .a(k1), .b(jt64), .p(k2));
		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_k3 (.clk, .en(adv), .a(k2), .b(jt64), .p(k3));
		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_ha (.clk, .en(adv), .a(QH), .b(a_a), .p(ha));
		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_haj (.clk, .en(adv), .a(ha), .b(jt64), .p(haj));
		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_hajj (
			.clk, .en(adv), .a(haj), .b(jt64), .p(hajj)
		);
		jlte_dly #(.W(64), .N(U+3-A)) u_hajj9 (.clk, .en(adv), .d(hajj), .q(hajj_u9));
		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_vj (.clk, .en(adv), .a(v_a[i]), .b(jt64), .p(vj));
		jlte_dly #(.W(64), .N(U+8-A)) u_vj10 (.clk, .en(adv), .d(vj), .q(vj_u10));
		jlte_dly #(.W(64), .N(U+11-A)) u_pu11 (.clk, .en(adv), .d(p_a[i]), .q(p_u11));

		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_l1 (.clk, .en(adv), .a(QH), .b(sd_s), .p(l1));
		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_l2 (.clk, .en(adv), .a(l1), .b(jt64), .p(l2));
		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_aj (.clk, .en(adv), .a(a_a), .b(jt64), .p(aj));
		jlte_dly #(.W(64), .N(U+5-A)) u_aj7 (.clk, .en(adv), .d(aj), .q(aj_u7));
		jlte_dly #(.W(64), .N(U+8-A-S)) u_vu8 (.clk, .en(adv), .d(v_as[i]), .q(v_u8));
		jlte_dly #(.W(64), .N(1)) u_vu9 (.clk, .en(adv), .d(v_u8), .q(v_u9));

		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_md (
			.clk, .en(adv), .a(v_u9), .b(vjs_s[i]), .p(m_d[i])
		);

		always_ff @(posedge clk) begin
			if (adv) begin
				sd_s <= ssub(ms, a_u2);
				q1_s <= sadd(k3, hajj_u9);
				q2_s <= sadd(q1_s, vj_u10);
				pjs_s[i] <= sadd(q2_s, p_u11);
				w1_s <= sadd(l2, aj_u7);
				vjs_s[i] <= sadd(w1_s, v_u8);
			end
		end

		// Braking distance along the stop direction.
		jlte_dly #(.W(64), .N(11+S+D)) u_unitd (.clk, .en(adv), .d(unit[i]), .q(unit_d));
		jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_mr (
			.clk, .en(adv), .a(brake_len), .b(sneg(unit_d)), .p(mr)
		);
		jlte_dly #(.W(64), .N(S+D+1)) u_pjsd (.clk, .en(adv), .d(pjs_s[i]), .q(pjs_d));

		always_ff @(posedge clk) begin
			if (adv) begin
				r_s[i] <= sadd(pjs_d, mr);
			end
		end

		jlte_dly #(.W(64), .N(E-A)) u_pe (.clk, .en(adv), .d(p_a[i]), .q(p_e[i]));
		jlte_dly #(.W(64), .N(E-A)) u_ve (.clk, .en(adv), .d(v_a[i]), .q(v_e[i]));
		jlte_dly #(.W(64), .N(E-U-12)) u_pjse (.clk, .en(adv), .d(pjs_s[i]), .q(pjs_e[i]));
	end

	// Velocity at t dotted with the velocity after the braking jerk.
	jlte_dly #(.W(64), .N(1)) u_m2d (.clk, .en(adv), .d(m_d[2]), .q(m2_d));

	always_ff @(posedge clk) begin
		if (adv) begin
			dot1_s <= sadd(m_d[0], m_d[1]);
			dot_s <= sadd(dot1_s, m2_d);
		end
	end

	jlte_norm u_sbrk (
		.clk, .en(adv), .x(vjs_s[0]), .y(vjs_s[1]), .z(vjs_s[2]), .n(s_brk)
	);
	jlte_mul #(.FRAC_BITS(FRAC_BITS)) u_ss (.clk, .en(adv), .a(s_brk), .b(s_brk), .p(ss));
	jlte_div #(.FRAC_BITS(FRAC_BITS)) u_dist (
		.clk, .en(adv), .a(ss), .b(brk2_q), .q(brake_len)
	);

	jlte_dly #(.W(2), .N(E)) u_ope (.clk, .en(adv), .d(op_s0), .q(op_e));
	jlte_dly #(.W(1), .N(E-A-S)) u_zero (.clk, .en(adv), .d(speed == '0), .q(zero_e));
	jlte_dly #(.W(1), .N(E-U-13)) u_inj (.clk, .en(adv), .d(dot_s[63]), .q(inj_e));

	always_comb begin
		res_d = '0;
		for (int i = 0; i < 3; i++) begin
			rsel[i] = '0;
		end
		unique case (op_e)
			OP_POS: begin
				rsel = p_e;
				res_d.zero_speed = zero_e;
			end
			OP_VEL: begin
				rsel = v_e;
				res_d.zero_speed = zero_e;
			end
			OP_STOP: begin
				res_d.zero_speed = zero_e;
				if (zero_e) begin
					rsel = p_e;
				end else if (inj_e) begin
					rsel = pjs_e;
					res_d.stopped_in_jerk = 1'b1;
				end else begin
					rsel = r_s;
				end
			end
			default: begin
				for (int i = 0; i < 3; i++) begin
					rsel[i] = '0;
				end
			end
		endcase
		res_d.out_x = sat32(rsel[0]);
		res_d.out_y = sat32(rsel[1]);
		res_d.out_z = sat32(rsel[2]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

/* rtl/jlte_chk.sv */
module jlte_chk import jlte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input item_t item,
	input logic res_valid,
	input logic res_stall,
	input res_t res,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic cfg_index,
	input logic [31:0] cfg_data
);

	// A stalled result beat stays and keeps its value.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result beat changed");

	// The pipeline holds input exactly while its output is blocked.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall == (res_valid && res_stall))
		else $error("item_stall does not follow the blocked output");

	// A stop inside the jerk phase needs a moving vehicle.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.stopped_in_jerk |-> !res.zero_speed)
		else $error("stop flag set at zero speed");

	// A rising result valid requires that the output was not blocked in the previous cycle.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!res_stall || !res_valid))
		else $error("result appeared while output blocked");

endmodule

bind jerk_limited_trajectory_eval_core jlte_chk u_jlte_chk (.*);
